>>> design/postfix_expression_evaluator_macros.svh
// Assertion macros for the postfix expression evaluator.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PFX_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pfx_pkg.sv
// Shared types and constants of the postfix expression evaluator.
`default_nettype none

package pfx_pkg;

    localparam int DataW = 32;
    localparam int StatW = 3;
    localparam int SymW  = 8;
    localparam int InW   = 8;
    localparam int OutW  = 40;

    localparam logic [SymW-1:0] ChZero  = 8'h30;
    localparam logic [SymW-1:0] ChNine  = 8'h39;
    localparam logic [SymW-1:0] ChPlus  = 8'h2B;
    localparam logic [SymW-1:0] ChMinus = 8'h2D;
    localparam logic [SymW-1:0] ChStar  = 8'h2A;
    localparam logic [SymW-1:0] ChSlash = 8'h2F;

    localparam logic [StatW-1:0] ST_OK    = 3'd0;
    localparam logic [StatW-1:0] ST_FEW   = 3'd1;
    localparam logic [StatW-1:0] ST_DIV0  = 3'd2;
    localparam logic [StatW-1:0] ST_LEFT  = 3'd3;
    localparam logic [StatW-1:0] ST_EMPTY = 3'd4;
    localparam logic [StatW-1:0] ST_OVER  = 3'd5;

    typedef struct packed {
        logic             start;
        logic [DataW-1:0] dividend;
        logic [DataW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DataW-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> design/pfx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module pfx_ram #(
    parameter int Width = 32,
    parameter int Depth = 127,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AddrW-1:0] i_waddr,
    input  wire logic [Width-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AddrW-1:0] i_raddr,
    output logic      [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/pfx_div.sv
// Radix-2 restoring signed divider, truncating toward zero.
`default_nettype none

module pfx_div import pfx_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CntW = $clog2(DataW);

    logic             r_busy;
    logic             r_fix;
    logic             r_done;
    logic             r_neg;
    logic [CntW-1:0]  r_cnt;
    logic [DataW:0]   r_rem;
    logic [DataW-1:0] r_quo;
    logic [DataW-1:0] r_dvs;
    logic [DataW-1:0] r_q;

    logic [DataW:0]   n_rem_sh;
    logic [DataW:0]   n_diff;
    logic [DataW:0]   n_rem;
    logic [DataW-1:0] n_quo;
    logic             a_neg;
    logic             b_neg;

    assign a_neg = i_req.dividend[DataW-1];
    assign b_neg = i_req.divisor[DataW-1];

    always_comb begin
        n_rem_sh = {r_rem[DataW-1:0], r_quo[DataW-1]};
        n_diff   = n_rem_sh - {1'b0, r_dvs};
        if (!n_diff[DataW]) begin
            n_rem = n_diff;
            n_quo = {r_quo[DataW-2:0], 1'b1};
        end else begin
            n_rem = n_rem_sh;
            n_quo = {r_quo[DataW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_fix) begin
                // sign correction of the magnitude quotient
                r_q    <= r_neg ? (DataW'(0) - r_quo) : r_quo;
                r_fix  <= 1'b0;
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + CntW'(1);
                if (r_cnt == CntW'(DataW - 1)) begin
                    r_fix <= 1'b1;
                end
            end else if (i_req.start) begin
                r_neg  <= a_neg ^ b_neg;
                r_quo  <= a_neg ? (DataW'(0) - i_req.dividend) : i_req.dividend;
                r_dvs  <= b_neg ? (DataW'(0) - i_req.divisor) : i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

`default_nettype wire

>>> design/postfix_expression_evaluator.sv
// Postfix evaluator: digits are taken in S_IDLE; + - * pass through S_OP (stack RAM
// read of the left operand), / through S_OP and S_DIV (radix-2 divider, one quotient
// bit per cycle). A word with tlast then passes through S_FIN to form the result; the
// result register lets the next expression start while the result waits to be taken.
// Reset (synchronous, active low) clears stack count, error and result valid;
// the stack RAM is not cleared, there is no clearing pass.
`default_nettype none
`include "postfix_expression_evaluator_macros.svh"

module postfix_expression_evaluator import pfx_pkg::*; #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire logic [InW-1:0]  i_s_axis_tdata,  // [7:0] symbol
    input  wire logic            i_s_axis_tlast,  // last
    output logic                 o_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    output logic      [OutW-1:0] o_m_axis_tdata   // [31:0] value, [34:32] status, rest zero
);

    localparam int CntW     = $clog2(STACK_DEPTH + 1);
    localparam int MemDepth = STACK_DEPTH - 1;
    localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

    typedef enum logic [1:0] {S_IDLE, S_OP, S_DIV, S_FIN} t_state;
    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} t_op;

    t_state           r_state;
    t_op              r_op;
    logic             r_last;
    logic [CntW-1:0]  r_count;
    logic [StatW-1:0] r_err;
    logic [DataW-1:0] r_tos;          // top of stack lives here, the rest in RAM
    logic             r_out_valid;
    logic [DataW-1:0] r_out_value;
    logic [StatW-1:0] r_out_status;

    logic             in_acc;
    logic [SymW-1:0]  sym;
    logic             is_digit;
    logic             is_op;
    t_op              n_op;
    logic [CntW-1:0]  cnt_m1;
    logic [CntW-1:0]  cnt_m2;
    logic             full;
    logic             ram_we;
    logic             ram_re;
    logic [DataW-1:0] lhs;
    logic [DataW-1:0] alu_res;
    logic [StatW-1:0] fin_status;
    logic [DataW-1:0] fin_value;
    logic             out_free;
    t_state           after_item;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign sym      = i_s_axis_tdata[SymW-1:0];
    assign is_digit = sym inside {[ChZero:ChNine]};
    assign is_op    = sym inside {ChPlus, ChMinus, ChStar, ChSlash};
    assign cnt_m1   = r_count - CntW'(1);
    assign cnt_m2   = r_count - CntW'(2);
    assign full     = r_count >= CntW'(STACK_DEPTH);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign after_item = r_last ? S_FIN : S_IDLE;

    always_comb begin
        case (sym)
            ChPlus:  n_op = OP_ADD;
            ChMinus: n_op = OP_SUB;
            ChStar:  n_op = OP_MUL;
            default: n_op = OP_DIV;
        endcase
    end

    // old top spills to RAM on a push; an operator reads its left operand
    assign ram_we = in_acc && (r_err == ST_OK) && is_digit && !full && (r_count != '0);
    assign ram_re = in_acc && (r_err == ST_OK) && is_op && (r_count >= CntW'(2));

    pfx_ram #(
        .Width (DataW),
        .Depth (MemDepth),
        .AddrW (AddrW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cnt_m1[AddrW-1:0]),
        .i_wdata (r_tos),
        .i_re    (ram_re),
        .i_raddr (cnt_m2[AddrW-1:0]),
        .o_rdata (lhs)
    );

    always_comb begin
        case (r_op)
            OP_ADD:  alu_res = lhs + r_tos;
            OP_SUB:  alu_res = lhs - r_tos;
            OP_MUL:  alu_res = lhs * r_tos;
            default: alu_res = '0;
        endcase
    end

    assign div_req.start    = (r_state == S_OP) && (r_op == OP_DIV) && (r_tos != '0);
    assign div_req.dividend = lhs;
    assign div_req.divisor  = r_tos;

    pfx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        fin_value = '0;
        if (r_err != ST_OK) begin
            fin_status = r_err;
        end else if (r_count == '0) begin
            fin_status = ST_EMPTY;
        end else if (r_count > CntW'(1)) begin
            fin_status = ST_LEFT;
        end else begin
            fin_status = ST_OK;
            fin_value  = r_tos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            // in S_FIN the result register is either refilled or still held
            if (r_out_valid && i_m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_last <= i_s_axis_tlast;
                        if (i_s_axis_tlast && !ram_re) begin
                            r_state <= S_FIN;
                        end
                        if (r_err == ST_OK) begin
                            if (is_digit) begin
                                if (full) begin
                                    r_err <= ST_OVER;
                                end else begin
                                    r_tos   <= DataW'(sym - ChZero);
                                    r_count <= r_count + CntW'(1);
                                end
                            end else if (is_op) begin
                                if (r_count < CntW'(2)) begin
                                    r_err <= ST_FEW;
                                end else begin
                                    r_op    <= n_op;
                                    r_state <= S_OP;
                                end
                            end
                        end
                    end
                end
                S_OP: begin
                    if (r_op == OP_DIV) begin
                        if (r_tos == '0) begin
                            r_err   <= ST_DIV0;
                            r_count <= cnt_m2;
                            r_state <= after_item;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_tos   <= alu_res;
                        r_count <= cnt_m1;
                        r_state <= after_item;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_tos   <= div_rsp.quotient;
                        r_count <= cnt_m1;
                        r_state <= after_item;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= fin_value;
                        r_out_status <= fin_status;
                        r_count      <= '0;
                        r_err        <= ST_OK;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OutW - DataW - StatW){1'b0}}, r_out_status, r_out_value};

    `PFX_ASSERT_IMPLY(a_count_bound, 1'b1, r_count <= CntW'(STACK_DEPTH),
                      "stack count beyond depth")
    `PFX_ASSERT_IMPLY(a_err_value_zero, o_m_axis_tvalid && (r_out_status != ST_OK),
                      r_out_value == '0, "nonzero value with error status")
    `PFX_ASSERT_IMPLY(a_div_owner, div_rsp.busy, r_state == S_DIV,
                      "divider busy outside divide state")
    `PFX_ASSERT_NEXT(a_last_to_fin, in_acc && i_s_axis_tlast && !is_op, r_state == S_FIN,
                     "last word did not close the expression")

endmodule

`default_nettype wire

>>> tb/tb_postfix_expression_evaluator.sv
// Self-checking testbench of the postfix evaluator: directed and random expressions vs a predictor.
import pfx_pkg::*;

typedef struct packed {
    logic [DataW-1:0] value;
    logic [StatW-1:0] status;
} pfx_result_t;

function automatic bit is_digit(logic [SymW-1:0] sym);
    return sym >= ChZero && sym <= ChNine;
endfunction

function automatic bit is_operator(logic [SymW-1:0] sym);
    return sym == ChPlus || sym == ChMinus || sym == ChStar || sym == ChSlash;
endfunction

class pfx_scoreboard #(int DEPTH = 128);
    logic [DataW-1:0] operands [DEPTH];
    int unsigned      depth;
    logic [StatW-1:0] err;
    pfx_result_t      expected_q [$];
    int unsigned      fails;

    function new();
        depth = 0;
        err   = ST_OK;
        fails = 0;
    endfunction

    // Evaluate one accepted word; queue the expected result on tlast.
    function void note_word(logic [SymW-1:0] sym, logic last);
        logic [DataW-1:0] rhs, lhs, res, mag_l, mag_r, quo;
        bit               div0;
        pfx_result_t      r;
        if (err == ST_OK) begin
            if (is_digit(sym)) begin
                if (depth >= DEPTH) begin
                    err = ST_OVER;
                end else begin
                    operands[depth] = DataW'(sym - ChZero);
                    depth++;
                end
            end else if (is_operator(sym)) begin
                if (depth < 2) begin
                    err = ST_FEW;
                end else begin
                    rhs   = operands[depth-1];
                    lhs   = operands[depth-2];
                    depth = depth - 2;
                    div0  = 1'b0;
                    res   = '0;
                    case (sym)
                        ChPlus:  res = lhs + rhs;
                        ChMinus: res = lhs - rhs;
                        ChStar:  res = lhs * rhs;
                        default: begin
                            if (rhs == '0) begin
                                div0 = 1'b1;
                            end else begin
                                // magnitudes, so most negative / -1 wraps cleanly
                                mag_l = lhs[DataW-1] ? -lhs : lhs;
                                mag_r = rhs[DataW-1] ? -rhs : rhs;
                                quo   = mag_l / mag_r;
                                res   = (lhs[DataW-1] ^ rhs[DataW-1]) ? -quo : quo;
                            end
                        end
                    endcase
                    if (div0) begin
                        err = ST_DIV0;
                    end else begin
                        operands[depth] = res;
                        depth++;
                    end
                end
            end
        end
        if (last) begin
            r.value = '0;
            if (err != ST_OK) begin
                r.status = err;
            end else if (depth == 0) begin
                r.status = ST_EMPTY;
            end else if (depth > 1) begin
                r.status = ST_LEFT;
            end else begin
                r.status = ST_OK;
                r.value  = operands[0];
            end
            expected_q.push_back(r);
            depth = 0;
            err   = ST_OK;
        end
    endfunction

    function void check_result(logic [OutW-1:0] word);
        pfx_result_t r;
        if (expected_q.size() == 0) begin
            $error("unexpected result word %h", word);
            fails++;
            return;
        end
        r = expected_q.pop_front();
        if (word[DataW +: StatW] !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, word[DataW +: StatW]);
            fails++;
        end
        if (word[DataW-1:0] !== r.value) begin
            $error("value: expected %0d, actual %0d", $signed(r.value),
                   $signed(word[DataW-1:0]));
            fails++;
        end
    endfunction
endclass

module tb_postfix_expression_evaluator;
    localparam int STACK_DEPTH    = 128;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 40;

    logic            i_clk           = 1'b0;
    logic            i_rst_n         = 1'b0;
    logic            i_s_axis_tvalid = 1'b0;
    logic [InW-1:0]  i_s_axis_tdata  = '0;
    logic            i_s_axis_tlast  = 1'b0;
    logic            i_m_axis_tready = 1'b0;
    logic            o_s_axis_tready;
    logic            o_m_axis_tvalid;
    logic [OutW-1:0] o_m_axis_tdata;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned items_sent    = 0;
    int unsigned hold_reqs     = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;

    logic [SymW-1:0] expr_q [$];
    pfx_scoreboard #(STACK_DEPTH) sb;

    postfix_expression_evaluator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] symbol
        .i_s_axis_tlast  (i_s_axis_tlast),   // last
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)    // [31:0] value, [34:32] status
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Handshake monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.note_word(i_s_axis_tdata, i_s_axis_tlast);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata);
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic [SymW-1:0] rand_digit();
        return ChZero + SymW'($urandom_range(9));
    endfunction

    function automatic logic [SymW-1:0] rand_op();
        case ($urandom_range(3))
            0:       return ChPlus;
            1:       return ChMinus;
            2:       return ChStar;
            default: return ChSlash;
        endcase
    endfunction

    function automatic logic [SymW-1:0] rand_ignored();
        logic [SymW-1:0] sym;
        do sym = SymW'($urandom_range(255)); while (is_digit(sym) || is_operator(sym));
        return sym;
    endfunction

    task automatic send_word(input logic [SymW-1:0] sym, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= sym;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_expr();
        if (expr_q.size() == 0)
            expr_q.push_back(rand_ignored());
        foreach (expr_q[i])
            send_word(expr_q[i], i == expr_q.size() - 1);
        expr_q.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            expr_q.push_back(s[i]);
        send_expr();
    endtask

    // Well-formed postfix with random digits and operators, optional junk characters.
    task automatic build_postfix(input int unsigned n_operands, input bit with_junk);
        int unsigned pushed;
        int unsigned level;
        pushed = 0;
        level  = 0;
        while (pushed < n_operands || level > 1) begin
            if (level >= 2 && (pushed == n_operands || $urandom_range(1) == 0)) begin
                expr_q.push_back(rand_op());
                level--;
            end else begin
                expr_q.push_back(rand_digit());
                pushed++;
                level++;
            end
            if (with_junk && $urandom_range(9) == 0)
                expr_q.push_back(rand_ignored());
        end
    endtask

    task automatic build_full_stack();
        repeat (STACK_DEPTH) expr_q.push_back(rand_digit());
        repeat (STACK_DEPTH - 1) expr_q.push_back(rand_op());
    endtask

    task automatic build_overflow();
        repeat (STACK_DEPTH + $urandom_range(1, 3)) expr_q.push_back(rand_digit());
        if ($urandom_range(1))
            expr_q.push_back(rand_op());
    endtask

    // 8^10 * 2 wraps to the most negative value, then divide by 0-1.
    task automatic build_most_negative_div();
        expr_q.push_back(ChZero + SymW'(8));
        repeat (9) begin
            expr_q.push_back(ChZero + SymW'(8));
            expr_q.push_back(ChStar);
        end
        expr_q.push_back(ChZero + SymW'(2));
        expr_q.push_back(ChStar);
        expr_q.push_back(ChZero);
        expr_q.push_back(ChZero + SymW'(1));
        expr_q.push_back(ChMinus);
        expr_q.push_back(ChSlash);
    endtask

    task automatic random_expr();
        int unsigned kind;
        int unsigned pos;
        kind = $urandom_range(999);
        if (kind < 3) begin
            build_full_stack();
        end else if (kind < 6) begin
            build_overflow();
        end else if (kind < 14) begin
            build_most_negative_div();
        end else if (kind < 600) begin
            build_postfix($urandom_range(1, 6), $urandom_range(3) == 0);
        end else if (kind < 700) begin
            build_postfix($urandom_range(7, 20), 1'b1);
        end else if (kind < 850) begin
            // broken: mutate a good expression
            build_postfix($urandom_range(1, 6), 1'b0);
            pos = $urandom_range(expr_q.size() - 1);
            case ($urandom_range(3))
                0:       expr_q.delete(pos);
                1:       expr_q.insert(pos, rand_digit());
                2:       expr_q.insert(pos, rand_op());
                default: expr_q.delete();
            endcase
        end else if (kind < 930) begin
            repeat ($urandom_range(1, 5)) expr_q.push_back(SymW'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 4))
                expr_q.push_back($urandom_range(1) ? rand_op() : rand_digit());
        end
        send_expr();
    endtask

    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input int unsigned n_items);
        int unsigned target;
        send_idle_pct = idle;
        stall_pct     = stall;
        target        = items_sent + n_items;
        while (items_sent < target)
            random_expr();
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every operator, truncating divide of a negative, error cases
        send_text("34+");
        send_text("92-");
        send_text("56*");
        send_text("07-2/");
        send_text("+");
        send_text("1+2");
        send_text("50/");
        send_text("12");
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(ChNine, 1'b1);

        // deep cases once up front, then random phases
        build_full_stack();
        send_expr();
        build_overflow();
        send_expr();
        build_most_negative_div();
        send_expr();

        run_phase(0, 0, 110);
        run_phase(61, 0, 110);
        run_phase(0, 61, 110);
        run_phase(6, 6, 110);

        // long receiver hold-off while words keep coming
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_reqs++;
        repeat (40) begin
            build_postfix(2, 1'b0);
            send_expr();
        end
        run_phase(0, 0, 40);

        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.fails == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
